// ===== rtl/psd_pkg.sv =====
`timescale 1ns / 1ps
package psd_pkg;
  typedef enum logic [3:0] {
    PH_SKIP, PH_DATA, PH_HUNT, PH_PACK, PH_LEN, PH_PES, PH_M2,
    PH_M1STUFF, PH_M1STD, PH_M1TAIL, PH_END
  } phase_t;

  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_PTS = 3'd1;
  localparam logic [2:0] K_BAD_PTS = 3'd2;
  localparam logic [2:0] K_END = 3'd3;
  localparam logic [2:0] K_BAD_ID = 3'd4;
  localparam logic [2:0] K_WEIRD_PACK = 3'd5;
  localparam logic [2:0] K_ES_SEEN = 3'd6;
  localparam logic [2:0] K_STUFF = 3'd7;

  localparam logic [0:0] REG_TRACK_ID = 1'b0;
  localparam logic [0:0] REG_TS_MODE = 1'b1;
  localparam logic [7:0] TRACK_RESET = 8'he0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [32:0] pts_value;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       unit_start;
  } item_t;
endpackage

// ===== rtl/psd_stream_if.sv =====
`timescale 1ns / 1ps
interface psd_stream_if #(parameter int W = 9);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/psd_parser.sv =====
`timescale 1ns / 1ps
module psd_parser
  import psd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] track_id,
  input  logic       ts_mode,
  output logic       res_valid,
  output result_t    res
);
  phase_t      phase, phase_next;
  logic [23:0] code_window, code_window_next;
  logic [8:0]  header_count, header_count_next;
  logic [8:0]  header_target, header_target_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [39:0] pts_shift, pts_shift_next;
  logic [7:0]  header_flags, header_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
      code_window <= '0;
      header_count <= '0;
      header_target <= '0;
      bytes_left <= '0;
      pts_shift <= '0;
      header_flags <= '0;
    end else if (step) begin
      phase <= phase_next;
      code_window <= code_window_next;
      header_count <= header_count_next;
      header_target <= header_target_next;
      bytes_left <= bytes_left_next;
      pts_shift <= pts_shift_next;
      header_flags <= header_flags_next;
    end
  end

  logic [7:0] b;
  assign b = item.data_byte;

  // PTS check on the captured bytes (phase/flags as given)
  function automatic void do_finish(input logic [7:0] fl, input logic [39:0] ps,
                                    output logic v, output result_t r);
    logic [7:0] h0, h1, h2, h3, h4;
    h0 = ps[39:32]; h1 = ps[31:24]; h2 = ps[23:16]; h3 = ps[15:8]; h4 = ps[7:0];
    r = '0;
    v = 1'b0;
    if (fl[7]) begin
      v = 1'b1;
      if (fl[2:0] != 3'd5 || (h0 & 8'he0) != 8'h20 || !h2[0] || !h4[0])
        r.kind = K_BAD_PTS;
      else begin
        r.kind = K_PTS;
        r.pts_value = {h0[3:1], h1, h2[7:1], h3, h4[7:1]};
      end
    end
  endfunction

  always_comb begin
    phase_t      ph;
    logic [8:0]  hc;
    logic [8:0]  idx;
    logic [3:0]  nib;
    logic [8:0]  skp;
    logic        fv;
    result_t     fr;
    logic [7:0]  cb;
    logic        stuff;
    ph = phase;
    hc = header_count;
    idx = '0;
    nib = b[7:4];
    skp = '0;
    fv = 1'b0;
    fr = '0;
    cb = b;
    stuff = 1'b0;
    phase_next = phase;
    code_window_next = code_window;
    header_count_next = header_count;
    header_target_next = header_target;
    bytes_left_next = bytes_left;
    pts_shift_next = pts_shift;
    header_flags_next = header_flags;
    res_valid = 1'b0;
    res = '0;

    if (phase != PH_END) begin
      if (item.unit_start) begin
        ph = PH_HUNT; hc = '0;
      end
      if ((ph == PH_SKIP || ph == PH_DATA) && !ts_mode && bytes_left == '0) begin
        ph = PH_HUNT; hc = '0;
      end
      if (ph == PH_END) begin
        ph = PH_HUNT; hc = '0;
      end
      phase_next = ph;
      header_count_next = hc;
      idx = hc;
      case (ph)
        PH_SKIP: begin
          if (!ts_mode) bytes_left_next = bytes_left - 17'd1;
        end
        PH_DATA: begin
          if (!ts_mode) bytes_left_next = bytes_left - 17'd1;
          res_valid = 1'b1;
          res.kind = K_PAYLOAD;
          res.payload_byte = b;
        end
        PH_HUNT: begin
          if (hc < 9'd3) begin
            code_window_next = {code_window[15:0], b};
            header_count_next = hc + 9'd1;
          end else if (code_window == 24'h000001) begin
            header_count_next = 9'd4;
            header_flags_next = '0;
            if (ts_mode) begin
              if (b >= 8'he0 && b <= 8'hef) phase_next = PH_PES;
              else begin
                phase_next = PH_SKIP;
                res_valid = 1'b1; res.kind = K_BAD_ID;
              end
            end else if (b == 8'hb9) begin
              phase_next = PH_END;
              res_valid = 1'b1; res.kind = K_END;
            end else if (b == 8'hba) phase_next = PH_PACK;
            else if (b == track_id) phase_next = PH_PES;
            else if (b < 8'hb9) begin
              phase_next = PH_HUNT; header_count_next = '0;
              res_valid = 1'b1; res.kind = K_ES_SEEN;
            end else phase_next = PH_LEN;
          end else if (ts_mode) phase_next = PH_SKIP;
          else code_window_next = {code_window[15:0], b};
        end
        PH_PACK: begin
          header_count_next = hc + 9'd1;
          if (idx == 9'd4) begin
            if ((b & 8'hc0) == 8'h40) begin
            end else if ((b & 8'hf0) == 8'h20) begin
              phase_next = PH_SKIP;
              bytes_left_next = 17'd7;
            end else begin
              phase_next = PH_HUNT; header_count_next = '0;
              res_valid = 1'b1; res.kind = K_WEIRD_PACK;
            end
          end else if (idx >= 9'd13) begin
            phase_next = PH_SKIP;
            bytes_left_next = {14'd0, b[2:0]};
          end
        end
        PH_LEN: begin
          header_count_next = hc + 9'd1;
          if (idx == 9'd4) bytes_left_next = {1'b0, b, 8'd0};
          else begin
            bytes_left_next = bytes_left | {9'd0, b};
            phase_next = PH_SKIP;
          end
        end
        default: begin
          // PES header phases
          if (ph == PH_PES && idx == 9'd4) begin
            header_count_next = hc + 9'd1;
            bytes_left_next = {1'b0, b, 8'd0};
          end else if (ph == PH_PES && idx == 9'd5) begin
            header_count_next = hc + 9'd1;
            bytes_left_next = bytes_left | {9'd0, b};
          end else begin
            header_count_next = hc + 9'd1;
            if (bytes_left != '0) bytes_left_next = bytes_left - 17'd1;
            if (ph == PH_PES && (b & 8'hc0) == 8'h80) begin
              phase_next = PH_M2;
            end else if (ph == PH_PES || ph == PH_M1STUFF) begin
              stuff = header_count_next >= 9'd24;
              if (!stuff && b == 8'hff) phase_next = PH_M1STUFF;
              else if ((b & 8'hc0) == 8'h40) begin
                phase_next = PH_M1STD;
                header_target_next = header_count_next + 9'd2;
              end else begin
                skp = (nib == 4'd2) ? 9'd4 : (nib == 4'd3) ? 9'd9 : 9'd0;
                if (skp == '0) begin
                  header_flags_next = b[5] ? 8'h80 : 8'h00;
                  phase_next = PH_DATA;
                  do_finish(header_flags_next, pts_shift, fv, fr);
                  res_valid = fv; res = fr;
                end else begin
                  header_flags_next = 8'h81;
                  pts_shift_next = {32'd0, b};
                  header_target_next = header_count_next + skp;
                  phase_next = PH_M1TAIL;
                end
              end
              if (stuff) begin
                res_valid = 1'b1; res = '0; res.kind = K_STUFF;
              end
            end else if (ph == PH_M1STD) begin
              if (header_count_next == header_target) begin
                skp = (nib == 4'd2) ? 9'd4 : (nib == 4'd3) ? 9'd9 : 9'd0;
                if (skp == '0) begin
                  header_flags_next = b[5] ? 8'h80 : 8'h00;
                  phase_next = PH_DATA;
                  do_finish(header_flags_next, pts_shift, fv, fr);
                  res_valid = fv; res = fr;
                end else begin
                  header_flags_next = 8'h81;
                  pts_shift_next = {32'd0, b};
                  header_target_next = header_count_next + skp;
                  phase_next = PH_M1TAIL;
                end
              end
            end else if (ph == PH_M2 && idx == 9'd7) begin
              header_flags_next = b & 8'h80;
            end else if (ph == PH_M2 && idx == 9'd8) begin
              header_target_next = 9'd9 + {1'b0, b};
              if (b == 8'd0) begin
                phase_next = PH_DATA;
                do_finish(header_flags, pts_shift, fv, fr);
                res_valid = fv; res = fr;
              end
            end else begin
              // PH_M2 data bytes or PH_M1TAIL
              if (header_flags[7] && header_flags[2:0] < 3'd5) begin
                pts_shift_next = {pts_shift[31:0], cb};
                header_flags_next = header_flags + 8'd1;
              end
              if (header_count_next == header_target) begin
                phase_next = PH_DATA;
                do_finish(header_flags_next, pts_shift_next, fv, fr);
                res_valid = fv; res = fr;
              end
            end
          end
        end
      endcase
    end
  end
endmodule

// ===== rtl/program_stream_pes_demux_top.sv =====
`timescale 1ns / 1ps
// MPEG program stream PES demultiplexer. One byte enters per cycle while the
// output side keeps taking results; each item gives at most one result, held in
// an output register and presented in the cycle after the byte is taken. The
// parse state is updated once per byte, so throughput is one item per clock
// whenever the output side keeps taking results. After the program end code the block drops all input until reset.
module program_stream_pes_demux_top
  import psd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  psd_stream_if.sink   in_ch,
  psd_stream_if.source out_ch
);
  logic [7:0] track_id;
  logic       ts_mode;
  logic       step;
  logic       res_valid;
  result_t    res;
  item_t      item;
  logic       ov;
  result_t    obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_id <= TRACK_RESET;
      ts_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACK_ID: track_id <= cfg_data;
        REG_TS_MODE: ts_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item = item_t'(in_ch.payload);
  assign in_ch.ready = !ov || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  psd_parser u_parser (
    .clk(clk), .rst(rst), .step(step), .item(item),
    .track_id(track_id), .ts_mode(ts_mode),
    .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (in_ch.ready) ov <= step && res_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && step && res_valid) obuf <= res;
  end

  assign out_ch.valid = ov;
  assign out_ch.payload = obuf;
endmodule
